// ----- sv/rgbgb_pkg.sv -----
// Shared constants and types of the RGB 3x3 Gaussian blur.
`timescale 1ns / 1ps

package rgbgb_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int LINE_ADDR_W = $clog2(MAX_WIDTH);

   localparam int SIZE_W     = 11;                 // frame size registers
   localparam int POS_W      = SIZE_W + 1;         // row count runs to height + 1
   localparam int COEF_W     = 17;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int PIX_W      = CHAN_W * NUM_CHAN;
   localparam int SUM3_W     = CHAN_W + 2;         // sum of four channel values
   localparam int PROD_W     = SUM3_W + COEF_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam int FRAC_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = COEF_W;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_COEF_CENTER  = 3'd2,
      CSR_COEF_EDGE    = 3'd3,
      CSR_COEF_CORNER  = 3'd4
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   typedef struct packed {
      logic prod_load;
      logic sum_load;
   } mac_ctrl_type;

endpackage

// ----- sv/rgb_gaussian_blur_3x3.sv -----
// Top level of the streaming RGB 3x3 Gaussian blur with clamp-to-edge borders.
`timescale 1ns / 1ps

// Streaming 3x3 Gaussian blur over RGB pixels in raster order.
// req_*: one pixel per request, tuser[0] = 1 marks a drain tick (no pixel).
// rsp_*: at most one filtered pixel per request, tlast on the last pixel of a frame.
// csr_*: write-only registers (frame width, height, three Q1.16 weights);
//   write them only while the block is idle. A size write restarts the frame.
// Throughput: one request per clock when not stalled, set by the single-read,
//   single-write line stores (one RAM each) and a fully pipelined kernel.
// Pipeline: the result caused by an accepted request passes the line store
//   read, window/neighbour sums, products, then round/saturate into the
//   output register.
// Output pixel k of a frame leaves with input request k + width + 1; the last
//   width + 1 pixels need drain ticks. Early drain ticks and pixels sent while
//   draining are dropped.
// Reset clears the positions, window and registers to their defaults; the
//   line stores need no clearing. When rsp_tready is low the pipeline keeps
//   filling its empty stages and req_tready falls only once all are full.
module rgb_gaussian_blur_3x3 (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = red[7:0], green[15:8], blue[23:16]; tuser = kind
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,
   input  logic [0:0]                        req_tuser,
   // response: tdata = red[7:0], green[15:8], blue[23:16]; tlast = frame end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [rgbgb_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [rgbgb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rgbgb_pkg::*;

   localparam logic [POS_W-1:0] MIN_SIZE = POS_W'(3);
   localparam logic [POS_W-1:0] MAX_W    = POS_W'(MAX_WIDTH);
   localparam logic [POS_W-1:0] MAX_H    = POS_W'(MAX_HEIGHT);

   function automatic column_type fix_col(column_type c, logic top_ok, logic bot_ok);
      column_type r;
      r = c;
      if (!top_ok) begin
         r.top = c.mid;
      end
      if (!bot_ok) begin
         r.bot = c.mid;
      end
      return r;
   endfunction

   // configuration
   logic [SIZE_W-1:0] frame_width_ff;
   logic [SIZE_W-1:0] frame_height_ff;
   logic [COEF_W-1:0] coef_center_ff;
   logic [COEF_W-1:0] coef_edge_ff;
   logic [COEF_W-1:0] coef_corner_ff;
   logic              size_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SIZE_W'(640);
         frame_height_ff <= SIZE_W'(480);
         coef_center_ff  <= COEF_W'(13384);
         coef_edge_ff    <= COEF_W'(8116);
         coef_corner_ff  <= COEF_W'(4922);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[SIZE_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[SIZE_W-1:0];
            end
            CSR_COEF_CENTER: begin
               coef_center_ff <= csr_wdata;
            end
            CSR_COEF_EDGE: begin
               coef_edge_ff <= csr_wdata;
            end
            CSR_COEF_CORNER: begin
               coef_corner_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign size_write = csr_we && (csr_index_type'(csr_addr) == CSR_FRAME_WIDTH ||
                                  csr_index_type'(csr_addr) == CSR_FRAME_HEIGHT);

   // effective sizes
   logic [POS_W-1:0] size_w;
   logic [POS_W-1:0] size_h;
   logic [POS_W-1:0] raw_w;
   logic [POS_W-1:0] raw_h;

   always_comb begin
      raw_w = POS_W'(frame_width_ff);
      raw_h = POS_W'(frame_height_ff);
      if (raw_w < MIN_SIZE) begin
         size_w = MIN_SIZE;
      end else if (raw_w > MAX_W) begin
         size_w = MAX_W;
      end else begin
         size_w = raw_w;
      end
      if (raw_h < MIN_SIZE) begin
         size_h = MIN_SIZE;
      end else if (raw_h > MAX_H) begin
         size_h = MAX_H;
      end else begin
         size_h = raw_h;
      end
   end

   // pipeline handshake
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_emit_ff;
   logic out_ready, s3_ready, s2_ready, s1_move;
   logic req_accept, is_drain, ignore_req, take;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s3_ready   = !s3_valid_ff || out_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_move    = s1_valid_ff && (!s1_emit_ff || s2_ready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   // positions
   logic [POS_W-1:0] in_col_ff, in_col_in;
   logic [POS_W-1:0] in_row_ff, in_row_in;
   logic [POS_W-1:0] out_col_ff, out_col_in;
   logic [POS_W-1:0] out_row_ff, out_row_in;
   logic emit, last, top_ok, bot_ok;

   always_comb begin
      is_drain   = req_tuser[0];
      ignore_req = is_drain ? (in_row_ff < size_h) : (in_row_ff >= size_h);
      take       = req_accept && !ignore_req;
      emit   = (in_row_ff >= POS_W'(2)) ||
               (in_row_ff == POS_W'(1) && in_col_ff >= POS_W'(1));
      top_ok = out_row_ff != '0;
      bot_ok = (out_row_ff + POS_W'(1)) < size_h;
      last   = ((out_row_ff + POS_W'(1)) >= size_h) &&
               ((out_col_ff + POS_W'(1)) >= size_w);
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (size_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if ((in_col_ff + POS_W'(1)) >= size_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + POS_W'(1);
         end else begin
            in_col_in = in_col_ff + POS_W'(1);
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if ((out_col_ff + POS_W'(1)) >= size_w) begin
               out_col_in = '0;
               out_row_in = out_row_ff + POS_W'(1);
            end else begin
               out_col_in = out_col_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // stage 1: line store read in flight
   logic                   s1_drain_ff;
   pixel_type              s1_px_ff;
   logic [LINE_ADDR_W-1:0] s1_addr_ff;
   logic                   s1_col0_ff, s1_col1_ff, s1_top_ok_ff, s1_bot_ok_ff, s1_last_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_tready) begin
         s1_drain_ff  <= is_drain;
         s1_px_ff     <= req_tdata;
         s1_addr_ff   <= in_col_ff[LINE_ADDR_W-1:0];
         s1_emit_ff   <= emit;
         s1_col0_ff   <= in_col_ff == '0;
         s1_col1_ff   <= in_col_ff == POS_W'(1);
         s1_top_ok_ff <= top_ok;
         s1_bot_ok_ff <= bot_ok;
         s1_last_ff   <= last;
      end
   end

   pixel_type prev_rdata, prev2_rdata;
   logic      line_we;

   assign line_we = s1_move && !s1_drain_ff;

   rgbgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev (
      .clock (clock),
      .we    (line_we),
      .waddr (s1_addr_ff),
      .wdata (s1_px_ff),
      .re    (take),
      .raddr (in_col_ff[LINE_ADDR_W-1:0]),
      .rdata (prev_rdata)
   );

   rgbgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev2 (
      .clock (clock),
      .we    (line_we),
      .waddr (s1_addr_ff),
      .wdata (prev_rdata),
      .re    (take),
      .raddr (in_col_ff[LINE_ADDR_W-1:0]),
      .rdata (prev2_rdata)
   );

   // window: two older columns; the centre is always the newer of them
   column_type win_old_ff, win_new_ff;
   column_type col_in, col_l, col_c, col_r;
   logic [CHAN_W-1:0] mid_sel [NUM_CHAN];
   logic [SUM3_W-1:0] side_sel [NUM_CHAN];
   logic [SUM3_W-1:0] diag_sel [NUM_CHAN];

   always_comb begin
      col_in.top = prev2_rdata;
      col_in.mid = prev_rdata;
      col_in.bot = s1_drain_ff ? prev_rdata : s1_px_ff;
      col_l = fix_col(s1_col1_ff ? win_new_ff : win_old_ff, s1_top_ok_ff, s1_bot_ok_ff);
      col_c = fix_col(win_new_ff, s1_top_ok_ff, s1_bot_ok_ff);
      col_r = fix_col(s1_col0_ff ? win_new_ff : col_in, s1_top_ok_ff, s1_bot_ok_ff);
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         mid_sel[ch]  = col_c.mid[ch*CHAN_W +: CHAN_W];
         side_sel[ch] = SUM3_W'(col_c.top[ch*CHAN_W +: CHAN_W]) +
                        SUM3_W'(col_c.bot[ch*CHAN_W +: CHAN_W]) +
                        SUM3_W'(col_l.mid[ch*CHAN_W +: CHAN_W]) +
                        SUM3_W'(col_r.mid[ch*CHAN_W +: CHAN_W]);
         diag_sel[ch] = SUM3_W'(col_l.top[ch*CHAN_W +: CHAN_W]) +
                        SUM3_W'(col_l.bot[ch*CHAN_W +: CHAN_W]) +
                        SUM3_W'(col_r.top[ch*CHAN_W +: CHAN_W]) +
                        SUM3_W'(col_r.bot[ch*CHAN_W +: CHAN_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_old_ff <= '0;
         win_new_ff <= '0;
      end else if (s1_move) begin
         win_old_ff <= win_new_ff;
         win_new_ff <= col_in;
      end
   end

   // stage 2: neighbour sums
   logic [CHAN_W-1:0] s2_mid_ff  [NUM_CHAN];
   logic [SUM3_W-1:0] s2_side_ff [NUM_CHAN];
   logic [SUM3_W-1:0] s2_diag_ff [NUM_CHAN];
   logic              s2_last_ff, s3_last_ff, rsp_last_ff;

   always_comb begin
      s2_valid_in  = s2_ready ? (s1_valid_ff && s1_emit_ff) : s2_valid_ff;
      s3_valid_in  = s3_ready ? s2_valid_ff : s3_valid_ff;
      rsp_valid_in = out_ready ? s3_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s2_ready) begin
         s2_last_ff <= s1_last_ff;
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            s2_mid_ff[ch]  <= mid_sel[ch];
            s2_side_ff[ch] <= side_sel[ch];
            s2_diag_ff[ch] <= diag_sel[ch];
         end
      end
      if (s3_ready) begin
         s3_last_ff <= s2_last_ff;
      end
      if (out_ready) begin
         rsp_last_ff <= s3_last_ff;
      end
   end

   // stages 3 and output: products, then round and saturate
   mac_ctrl_type mac_ctrl;

   assign mac_ctrl.prod_load = s3_ready;
   assign mac_ctrl.sum_load  = out_ready;

   for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
      rgbgb_mac u_mac (
         .clock       (clock),
         .ctrl        (mac_ctrl),
         .mid_val     (s2_mid_ff[ch]),
         .side_sum    (s2_side_ff[ch]),
         .diag_sum    (s2_diag_ff[ch]),
         .coef_center (coef_center_ff),
         .coef_edge   (coef_edge_ff),
         .coef_corner (coef_corner_ff),
         .value       (rsp_tdata[ch*CHAN_W +: CHAN_W])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- sv/rgbgb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rgbgb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/rgbgb_mac.sv -----
// One channel of the kernel: weight products, rounding up and saturation.
`timescale 1ns / 1ps

module rgbgb_mac (
   input  logic                          clock,
   input  rgbgb_pkg::mac_ctrl_type       ctrl,
   input  logic [rgbgb_pkg::CHAN_W-1:0]  mid_val,
   input  logic [rgbgb_pkg::SUM3_W-1:0]  side_sum,
   input  logic [rgbgb_pkg::SUM3_W-1:0]  diag_sum,
   input  logic [rgbgb_pkg::COEF_W-1:0]  coef_center,
   input  logic [rgbgb_pkg::COEF_W-1:0]  coef_edge,
   input  logic [rgbgb_pkg::COEF_W-1:0]  coef_corner,
   output logic [rgbgb_pkg::CHAN_W-1:0]  value
);
   import rgbgb_pkg::*;

   localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << FRAC_W) - 1);
   localparam logic [ACC_W-FRAC_W-1:0] CHAN_MAX = (ACC_W-FRAC_W)'((1 << CHAN_W) - 1);

   logic [PROD_W-1:0]        p_mid_ff;
   logic [PROD_W-1:0]        p_side_ff;
   logic [PROD_W-1:0]        p_diag_ff;
   logic [ACC_W-1:0]         total;
   logic [ACC_W-FRAC_W-1:0]  whole;
   logic [CHAN_W-1:0]        sat_in;
   logic [CHAN_W-1:0]        value_ff;

   always_ff @(posedge clock) begin
      if (ctrl.prod_load) begin
         p_mid_ff  <= PROD_W'(mid_val) * PROD_W'(coef_center);
         p_side_ff <= PROD_W'(side_sum) * PROD_W'(coef_edge);
         p_diag_ff <= PROD_W'(diag_sum) * PROD_W'(coef_corner);
      end
   end

   always_comb begin
      total = ACC_W'(p_mid_ff) + ACC_W'(p_side_ff) + ACC_W'(p_diag_ff) + ROUND_BIAS;
      whole = total[ACC_W-1:FRAC_W];
      sat_in = (whole > CHAN_MAX) ? {CHAN_W{1'b1}} : whole[CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_load) begin
         value_ff <= sat_in;
      end
   end

   assign value = value_ff;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the streaming RGB 3x3 Gaussian blur with clamp-to-edge borders.
`timescale 1ns / 1ps

module testbench;
   import rgbgb_pkg::*;

   localparam bit            KIND_PIXEL    = 1'b0;
   localparam bit            KIND_DRAIN    = 1'b1;
   localparam logic [2:0]    CSR_SPARE_IDX = 3'd7;   // no register decoded here
   localparam int            QUIET_LIMIT   = 3000;
   localparam int            SETTLE_CYCLES = 8;
   localparam int            RANDOM_ITEMS  = 470;

   typedef struct {
      bit         kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_req_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blur_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;   // red, green, blue from bit 0 up
   logic [0:0]            req_tuser = '0;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;        // red, green, blue from bit 0 up
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rgb_gaussian_blur_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   pixel_req_type   pixel_reqs_q [$];
   blur_result_type blurred_pixels_q [$];
   pixel_req_type   req_in_flight;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           send_gap = 0;
   int           stall_left = 0;
   int           quiet_cycles = 0;
   int           mismatch_count = 0;
   int           random_items = 0;

   // Shadow of the block: registers, line stores, window and positions
   logic [10:0]   cfg_width, cfg_height;
   logic [16:0]   w_centre, w_side, w_diag;
   logic [23:0]   row_above [0:MAX_WIDTH-1];
   logic [23:0]   row_above2 [0:MAX_WIDTH-1];
   logic [23:0]   win [0:8];                    // [column * 3 + row], column 2 newest
   int unsigned   in_col, in_row, out_col, out_row;

   logic [23:0] edge_pixels [0:8] = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
      24'hFF0000, 24'h808080, 24'h7F7F7F, 24'h030201, 24'hFCFDFE};

   function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic logic [7:0] blur_channel(input int l, input int c, input int r,
                                               input bit top_ok, input bit bot_ok,
                                               input int sh);
      int                cols [3];
      longint unsigned   side, diag, centre, total;
      logic [7:0]        t, m, b;
      int                k;
      cols[0] = l;
      cols[1] = c;
      cols[2] = r;
      side = 0;
      diag = 0;
      for (k = 0; k < 3; k++) begin
         m = win[cols[k] * 3 + 1][sh +: 8];
         t = top_ok ? win[cols[k] * 3][sh +: 8] : m;
         b = bot_ok ? win[cols[k] * 3 + 2][sh +: 8] : m;
         if (k == 1) begin
            side = side + t + b;
         end else begin
            side = side + m;
            diag = diag + t + b;
         end
      end
      centre = win[c * 3 + 1][sh +: 8];
      total = centre * w_centre + side * w_side + diag * w_diag;
      total = (total + 65535) >> 16;
      return (total > 255) ? 8'hFF : total[7:0];
   endfunction

   function automatic logic [23:0] blur_pixel(input int l, input int c, input int r,
                                              input bit top_ok, input bit bot_ok);
      return {blur_channel(l, c, r, top_ok, bot_ok, 16),
              blur_channel(l, c, r, top_ok, bot_ok, 8),
              blur_channel(l, c, r, top_ok, bot_ok, 0)};
   endfunction

   task automatic predict_blur(input pixel_req_type it);
      int unsigned    w, h, col;
      logic [23:0]    top, mid, bot, px, rgb;
      bit             emit, top_ok, bot_ok, last;
      blur_result_type res;
      int             k;
      w = eff_size(cfg_width, MAX_WIDTH);
      h = eff_size(cfg_height, MAX_HEIGHT);
      // early drain ticks and pixels sent while draining are dropped
      if (it.kind == KIND_PIXEL && in_row >= h) return;
      if (it.kind == KIND_DRAIN && in_row < h) return;
      col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
      px = {it.blue, it.green, it.red};
      top = row_above2[col];
      mid = row_above[col];
      bot = (it.kind == KIND_DRAIN) ? mid : px;
      if (it.kind == KIND_PIXEL) begin
         row_above2[col] = mid;
         row_above[col] = px;
      end
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      top_ok = out_row != 0;
      bot_ok = out_row + 1 < h;
      rgb = '0;
      // first column of a row: the centre is the last column of the row before
      if (emit && in_col == 0) rgb = blur_pixel(1, 2, 2, top_ok, bot_ok);
      for (k = 0; k < 6; k++) win[k] = win[k + 3];
      win[6] = top;
      win[7] = mid;
      win[8] = bot;
      if (emit && in_col != 0) rgb = blur_pixel((in_col == 1) ? 1 : 0, 1, 2, top_ok, bot_ok);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return;
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.red = rgb[7:0];
      res.green = rgb[15:8];
      res.blue = rgb[23:16];
      res.frame_end = last;
      blurred_pixels_q.push_back(res);
      if (last) begin
         {in_col, in_row, out_col, out_row} = '0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   // Driver: request channel
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_blur(req_in_flight);
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pixel_reqs_q.size() != 0 && send_idle_pct != 0 &&
                      $urandom_range(0, 99) < send_idle_pct) begin
            send_gap <= $urandom_range(0, 14);
            req_tvalid <= 1'b0;
         end else if (pixel_reqs_q.size() != 0) begin
            req_in_flight = pixel_reqs_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {req_in_flight.blue, req_in_flight.green, req_in_flight.red};
            req_tuser <= req_in_flight.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: response channel and its back-pressure
   always @(posedge clock) begin : rsp_monitor
      blur_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blurred_pixels_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result rgb %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = blurred_pixels_q.pop_front();
            if (rsp_tdata[7:0] !== want.red || rsp_tdata[15:8] !== want.green ||
                rsp_tdata[23:16] !== want.blue || rsp_tlast !== want.frame_end) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d %0d %0d last %b, got %0d %0d %0d last %b",
                           want.red, want.green, want.blue, want.frame_end,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
            end
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles with no request or response accepted
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_req(input bit kind, input logic [31:0] raw);
      pixel_req_type it;
      it.kind = kind;
      it.red = raw[7:0];
      it.green = raw[15:8];
      it.blue = raw[23:16];
      pixel_reqs_q.push_back(it);
   endtask

   task automatic wait_for_results();
      while (pixel_reqs_q.size() != 0 || req_tvalid || blurred_pixels_q.size() != 0)
         @(posedge clock);
   endtask

   // dropped requests may still be in the pipe when the last result is out
   task automatic settle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_FRAME_WIDTH: begin
            cfg_width = val[10:0];
            {in_col, in_row, out_col, out_row} = '0;
         end
         CSR_FRAME_HEIGHT: begin
            cfg_height = val[10:0];
            {in_col, in_row, out_col, out_row} = '0;
         end
         CSR_COEF_CENTER: w_centre = val;
         CSR_COEF_EDGE:   w_side = val;
         CSR_COEF_CORNER: w_diag = val;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_weights(input logic [16:0] c, input logic [16:0] e,
                              input logic [16:0] d);
      write_reg(CSR_COEF_CENTER, c);
      write_reg(CSR_COEF_EDGE, e);
      write_reg(CSR_COEF_CORNER, d);
   endtask

   // One frame at the current size with random content; dropped requests are mixed in.
   // abort_at cuts the frame short, hold_at waits for every result mid-frame.
   task automatic push_frame(input int abort_at, input int hold_at);
      int            w, h, i, c, mode;
      logic [31:0]   base, raw;
      w = eff_size(cfg_width, MAX_WIDTH);
      h = eff_size(cfg_height, MAX_HEIGHT);
      mode = $urandom_range(0, 2);
      base = $urandom;
      for (i = 0; i < w * h; i++) begin
         if (i == abort_at) return;
         if (i == hold_at) wait_for_results();
         if ($urandom_range(0, 19) == 0) push_req(KIND_DRAIN, $urandom);
         raw = $urandom;
         if (mode == 1) begin
            for (c = 0; c < 3; c++) raw[8 * c +: 8] = raw[8 * c] ? 8'hFF : 8'h00;
         end else if (mode == 2) begin
            raw = base ^ (raw & 32'h00070707);
         end
         push_req(KIND_PIXEL, raw);
         random_items++;
      end
      for (i = 0; i <= w; i++) begin
         if ($urandom_range(0, 9) == 0) push_req(KIND_PIXEL, $urandom);
         push_req(KIND_DRAIN, $urandom);
         random_items++;
      end
   endtask

   initial begin : stimulus
      int            i, phase, frames, sel, total;
      logic [16:0]   w_raw, h_raw;
      cfg_width = 11'd640;
      cfg_height = 11'd480;
      w_centre = 17'd13384;
      w_side = 17'd8116;
      w_diag = 17'd4922;
      for (i = 0; i < MAX_WIDTH; i++) begin
         row_above[i] = '0;
         row_above2[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i] = '0;
      {in_col, in_row, out_col, out_row} = '0;
      send_idle_pct = 20;
      recv_stall_pct = 20;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: far too wide for anything to come out yet
      push_req(KIND_DRAIN, $urandom);
      for (i = 0; i < 5; i++) push_req(KIND_PIXEL, $urandom);
      settle();

      // smallest frame, extreme pixels, reset weights
      write_reg(CSR_FRAME_WIDTH, 17'd3);
      write_reg(CSR_FRAME_HEIGHT, 17'd3);
      end_writes();
      push_req(KIND_DRAIN, 32'h00FFFFFF);
      foreach (edge_pixels[i]) push_req(KIND_PIXEL, {8'h00, edge_pixels[i]});
      push_req(KIND_DRAIN, 32'h0);
      push_req(KIND_PIXEL, 32'h00FFFFFF);
      for (i = 0; i < 3; i++) push_req(KIND_DRAIN, $urandom);
      settle();

      // identity kernel; undersized frame with junk above bit 10; spare index ignored
      set_weights(17'h10000, 17'h0, 17'h0);
      write_reg(CSR_FRAME_WIDTH, 17'h1F802);
      write_reg(CSR_FRAME_HEIGHT, 17'h0);
      write_reg(CSR_SPARE_IDX, 17'h1FFFF);
      end_writes();
      push_frame(-1, -1);
      settle();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle();
         sel = $urandom_range(0, 2);
         send_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 40;
         sel = $urandom_range(0, 2);
         recv_stall_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 40;
         case ($urandom_range(0, 6))
            0: set_weights(17'd13384, 17'd8116, 17'd4922);
            1: set_weights(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                           17'($urandom_range(0, 65536)));
            2: set_weights(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
                           17'($urandom_range(0, 131071)));
            3: set_weights(17'h0, 17'h0, 17'h0);
            4: set_weights(17'h10000, 17'h10000, 17'h10000);
            5: set_weights(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
            default: write_reg(CSR_COEF_EDGE, 17'($urandom_range(0, 16384)));
         endcase
         // a few phases at the largest sizes, the rest small
         case (phase)
            2: begin
               w_raw = 17'd1024;
               h_raw = 17'd2;
            end
            5: begin
               w_raw = 17'd2047;
               h_raw = 17'd3;
            end
            8: begin
               w_raw = 17'd3;
               h_raw = 17'd2047;
            end
            default: begin
               w_raw = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 2))
                                                   : 17'($urandom_range(3, 9));
               h_raw = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 2))
                                                   : 17'($urandom_range(3, 6));
               if ($urandom_range(0, 3) == 0) w_raw[16:11] = 6'($urandom_range(0, 63));
               if ($urandom_range(0, 3) == 0) h_raw[16:11] = 6'($urandom_range(0, 63));
            end
         endcase
         write_reg(CSR_FRAME_WIDTH, w_raw);
         write_reg(CSR_FRAME_HEIGHT, h_raw);
         end_writes();
         if (phase == 2 || phase == 5 || phase == 8) begin
            send_idle_pct = 10;
            recv_stall_pct = 10;
            // only the start of a large frame; a size write restarts it
            push_frame($urandom_range(120, 200), $urandom_range(1, 100));
            settle();
            write_reg(CSR_FRAME_WIDTH, w_raw);
            end_writes();
         end else begin
            total = eff_size(cfg_width, MAX_WIDTH) * eff_size(cfg_height, MAX_HEIGHT);
            frames = $urandom_range(1, 3);
            for (i = 0; i < frames; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  // cut the frame short; a size write restarts it
                  push_frame($urandom_range(1, total - 1), -1);
                  settle();
                  write_reg(CSR_FRAME_WIDTH, w_raw);
                  end_writes();
               end else begin
                  push_frame(-1, ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1)
                                                             : -1);
               end
            end
         end
         phase++;
      end

      // closing stretch at full rate on both sides
      settle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_weights(17'd13384, 17'd8116, 17'd4922);
      write_reg(CSR_FRAME_WIDTH, 17'd5);
      write_reg(CSR_FRAME_HEIGHT, 17'd4);
      end_writes();
      push_frame(-1, -1);
      push_frame(-1, -1);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
